// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is low
`define XMB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the rising clock, off while reset is low
`define XMB_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== sv/xmb_pkg.sv =====
// package with the constants of the xmodem block framer
package xmb_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);

    localparam logic [7:0]  SOH_CODE = 8'h01;
    localparam logic [7:0]  EOT_CODE = 8'h04;
    localparam logic [7:0]  PAD_CODE = 8'h1A;
    localparam logic [7:0]  MAX_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int          APB_AW            = 3;
    localparam logic [APB_AW-1:0] ADDR_CRC_MODE = 3'd0;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOF  = 1'b1;

    function automatic logic [15:0] crc_bit_step(input logic [15:0] c);
        logic [15:0] sh;
        sh = {c[14:0], 1'b0};
        return c[15] ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

// ===== sv/xmodem_block_framer_core.sv =====
// xmodem block framer top level with bit-serial crc sequencer
// usage:
//   input channel (in_valid, in_stall, func, data_byte): func 0 carries one
//   file byte, func 1 closes the file. in_stall is high while a word is at
//   work, the block takes one word at a time.
//   output channel (out_valid, out_stall, frame_byte, repeat_count,
//   block_end, last_of_run): one output register; a header byte, data byte,
//   padding run, trailer byte or eot per word, last_of_run on the last one.
//   the crc is updated one bit per cycle. a data word gives 1 to 4
//   results. end of file with n bytes in the open frame absorbs 128-n
//   padding bytes, then gives 4 or 5 results; on a frame boundary it
//   gives the two eot words.
//   a stalled receiver holds the output register and the sequencer waits.
//   reset: crc_mode is 1, block number 1, empty frame, nothing pending.
//   crc_mode is to be written over the apb port only while the block is
//   idle; the block itself does not enforce this.
module xmodem_block_framer_core
    import xmb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        frame_byte,
    output logic [7:0]        repeat_count,
    output logic              block_end,
    output logic              last_of_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ABS    = 4'd1;
    localparam logic [3:0] S_PADLD  = 4'd2;
    localparam logic [3:0] S_SOH    = 4'd3;
    localparam logic [3:0] S_NUM    = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_DATA   = 4'd6;
    localparam logic [3:0] S_PADRUN = 4'd7;
    localparam logic [3:0] S_TRL_HI = 4'd8;
    localparam logic [3:0] S_TRL_LO = 4'd9;
    localparam logic [3:0] S_EOT1   = 4'd10;
    localparam logic [3:0] S_EOT2   = 4'd11;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_BYTES);

    logic [3:0]        state_reg, state_next;
    logic              crc_mode_reg, crc_mode_next;
    logic [7:0]        block_num_reg, block_num_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] pad_left_reg, pad_left_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        sum_reg, sum_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic              eof_reg, eof_next;
    logic [7:0]        byte_reg, byte_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        frame_byte_reg, frame_byte_next;
    logic [7:0]        repeat_reg, repeat_next;
    logic              block_end_reg, block_end_next;
    logic              last_reg, last_next;

    logic              in_acc;
    logic              slot_free;
    logic              emit;
    logic              cfg_wr;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] pad_total;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign fill_inc  = fill_reg + 1'b1;
    assign pad_total = FILL_FULL - fill_reg;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CRC_MODE);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CRC_MODE) ? {31'd0, crc_mode_reg} : 32'd0;

    assign out_valid    = out_valid_reg;
    assign frame_byte   = frame_byte_reg;
    assign repeat_count = repeat_reg;
    assign block_end    = block_end_reg;
    assign last_of_run  = last_reg;

    // emit states need a free output slot
    always_comb
    begin
        emit = 1'b0;
        unique case (state_reg) inside
            S_SOH, S_NUM, S_CMP, S_DATA, S_PADRUN,
            S_TRL_HI, S_TRL_LO, S_EOT1, S_EOT2: emit = slot_free;
            default: emit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        crc_mode_next   = cfg_wr ? pwdata[0] : crc_mode_reg;
        block_num_next  = block_num_reg;
        fill_next       = fill_reg;
        pad_left_next   = pad_left_reg;
        crc_next        = crc_reg;
        sum_next        = sum_reg;
        bit_cnt_next    = bit_cnt_reg;
        eof_next        = eof_reg;
        byte_next       = byte_reg;
        out_valid_next  = out_valid_reg && out_stall;
        frame_byte_next = frame_byte_reg;
        repeat_next     = repeat_reg;
        block_end_next  = block_end_reg;
        last_next       = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            repeat_next    = 8'd1;
            block_end_next = 1'b0;
            last_next      = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    bit_cnt_next = 3'd0;
                    if (func == FUNC_DATA)
                    begin
                        eof_next   = 1'b0;
                        byte_next  = data_byte;
                        crc_next   = crc_reg ^ {data_byte, 8'd0};
                        sum_next   = sum_reg + data_byte;
                        state_next = S_ABS;
                    end
                    else
                    begin
                        eof_next = 1'b1;
                        if (fill_reg != '0)
                        begin
                            pad_left_next = pad_total;
                            state_next    = S_PADLD;
                        end
                        else
                        begin
                            state_next = S_EOT1;
                        end
                    end
                end
            end
            S_PADLD:
            begin
                crc_next     = crc_reg ^ {PAD_CODE, 8'd0};
                sum_next     = sum_reg + PAD_CODE;
                bit_cnt_next = 3'd0;
                state_next   = S_ABS;
            end
            S_ABS:
            begin
                crc_next     = crc_bit_step(crc_reg);
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 3'd7)
                begin
                    if (eof_reg)
                    begin
                        pad_left_next = pad_left_reg - 1'b1;
                        state_next    = (pad_left_reg == FILL_W'(1)) ? S_PADRUN : S_PADLD;
                    end
                    else
                    begin
                        state_next = (fill_reg == '0) ? S_SOH : S_DATA;
                    end
                end
            end
            S_SOH:
            begin
                if (emit)
                begin
                    frame_byte_next = SOH_CODE;
                    state_next      = S_NUM;
                end
            end
            S_NUM:
            begin
                if (emit)
                begin
                    frame_byte_next = block_num_reg;
                    state_next      = S_CMP;
                end
            end
            S_CMP:
            begin
                if (emit)
                begin
                    frame_byte_next = MAX_BYTE - block_num_reg;
                    state_next      = S_DATA;
                end
            end
            S_DATA:
            begin
                if (emit)
                begin
                    frame_byte_next = byte_reg;
                    fill_next       = fill_inc;
                    if (fill_inc == FILL_FULL)
                    begin
                        state_next = crc_mode_reg ? S_TRL_HI : S_TRL_LO;
                    end
                    else
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PADRUN:
            begin
                if (emit)
                begin
                    frame_byte_next = PAD_CODE;
                    repeat_next     = pad_total[7:0];
                    state_next      = crc_mode_reg ? S_TRL_HI : S_TRL_LO;
                end
            end
            S_TRL_HI:
            begin
                if (emit)
                begin
                    frame_byte_next = crc_reg[15:8];
                    state_next      = S_TRL_LO;
                end
            end
            S_TRL_LO:
            begin
                if (emit)
                begin
                    frame_byte_next = crc_mode_reg ? crc_reg[7:0] : sum_reg;
                    block_end_next  = 1'b1;
                    last_next       = !eof_reg;
                    block_num_next  = block_num_reg + 1'b1;
                    fill_next       = '0;
                    crc_next        = '0;
                    sum_next        = '0;
                    state_next      = eof_reg ? S_EOT1 : S_IDLE;
                end
            end
            S_EOT1:
            begin
                if (emit)
                begin
                    frame_byte_next = EOT_CODE;
                    state_next      = S_EOT2;
                end
            end
            S_EOT2:
            begin
                if (emit)
                begin
                    frame_byte_next = EOT_CODE;
                    last_next       = 1'b1;
                    block_num_next  = 8'd1;
                    fill_next       = '0;
                    crc_next        = '0;
                    sum_next        = '0;
                    eof_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            crc_mode_reg  <= 1'b1;
            block_num_reg <= 8'd1;
            fill_reg      <= '0;
            pad_left_reg  <= '0;
            crc_reg       <= '0;
            sum_reg       <= '0;
            bit_cnt_reg   <= '0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_mode_reg  <= crc_mode_next;
            block_num_reg <= block_num_next;
            fill_reg      <= fill_next;
            pad_left_reg  <= pad_left_next;
            crc_reg       <= crc_next;
            sum_reg       <= sum_next;
            bit_cnt_reg   <= bit_cnt_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        frame_byte_reg <= frame_byte_next;
        repeat_reg     <= repeat_next;
        block_end_reg  <= block_end_next;
        last_reg       <= last_next;
    end

endmodule

// ===== sv/xmb_checker.sv =====
// port-level assertions for the xmodem block framer, bound to the top level
`include "assert_macros.svh"

module xmb_checker
    import xmb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic [7:0] repeat_count,
    input logic       block_end,
    input logic       last_of_run
);

    `XMB_ASSERT_IMP(a_out_hold, out_valid && out_stall,
        ##1 (out_valid && $stable(frame_byte) && $stable(repeat_count)), "stalled word changed")
    `XMB_ASSERT_IMP(a_busy_after_accept, in_valid && !in_stall, ##1 in_stall,
        "input taken while a word is at work")
    `XMB_ASSERT_IMP(a_run_is_pad, out_valid && (repeat_count != 8'd1),
        (frame_byte == PAD_CODE) && !block_end && !last_of_run, "repeat on a non-pad byte")
    `XMB_ASSERT_IMP(a_count_nonzero, out_valid, repeat_count != 8'd0, "zero repeat count")

endmodule

bind xmodem_block_framer_core xmb_checker u_xmb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .repeat_count (repeat_count),
    .block_end    (block_end),
    .last_of_run  (last_of_run)
);
